// ----- src/bfme_pkg.sv -----
package bfme_pkg;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] bit_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bit_was;
    logic [7:0] found_position;
  } rsp_t;

  localparam logic [3:0] ACT_TEST       = 4'd0;
  localparam logic [3:0] ACT_SET        = 4'd1;
  localparam logic [3:0] ACT_CLEAR      = 4'd2;
  localparam logic [3:0] ACT_FLIP       = 4'd3;
  localparam logic [3:0] ACT_TEST0_SET  = 4'd4;
  localparam logic [3:0] ACT_TEST1_CLR  = 4'd5;
  localparam logic [3:0] ACT_HIGH_SET   = 4'd6;
  localparam logic [3:0] ACT_HIGH_ZERO  = 4'd7;
  localparam logic [3:0] ACT_LOW_SET    = 4'd8;
  localparam logic [3:0] ACT_LOW_ZERO   = 4'd9;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_NONE    = 2'd2;

  localparam logic [8:0] BITS_IN_USE_RESET = 9'd256;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
    logic out_direct;
    logic pend_load;
    logic out_pend;
  } cmd_t;

  typedef struct packed {
    logic eval_done;
  } sts_t;

endpackage

// ----- src/bfme_ctrl.sv -----
module bfme_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  bfme_pkg::sts_t sts,
  output bfme_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.eval_done) begin
          cmd.commit = 1'b1;
          if (slot_free) begin
            cmd.out_direct = 1'b1;
            rsp_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            cmd.pend_load = 1'b1;
            state_next    = ST_POST;
          end
        end
      end
      ST_POST: begin
        if (slot_free) begin
          cmd.out_pend   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- src/bfme_datapath.sv -----
module bfme_datapath #(
  parameter int WORD_BITS = 32,
  parameter int WORDS     = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [8:0]     cfg_wr_data,
  input  bfme_pkg::req_t req_data,
  output bfme_pkg::rsp_t rsp_data,
  input  bfme_pkg::cmd_t cmd,
  output bfme_pkg::sts_t sts
);

  localparam int MAP_BITS = WORDS * WORD_BITS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW = $clog2(WORD_BITS);
  localparam int CW = ($clog2(MAP_BITS + 1) > 9) ? $clog2(MAP_BITS + 1) : 9;

  logic [8:0]           bits_in_use;
  logic [3:0]           act;
  logic [CW-1:0]        limit;
  logic                 in_rng;
  logic [OW-1:0]        off;
  logic [AW-1:0]        iss_w;
  logic [AW-1:0]        ev_w;
  logic [CW-1:0]        iss_base;
  logic [CW-1:0]        ev_base;
  logic                 iss_active;
  logic                 iss_last;
  logic                 ev_live;
  logic                 ev_last;
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     vbits;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;
  logic [7:0]           qtab [256];
  logic [OW-1:0]        otab [256];
  bfme_pkg::rsp_t       pend;
  bfme_pkg::rsp_t       res;

  logic                 ld_search;
  logic                 ld_high;
  logic                 ld_in_rng;
  logic                 is_search;
  logic                 high;
  logic                 want;
  logic [WORD_BITS-1:0] data;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [OW-1:0]        pos;
  logic [CW:0]          found_sum;
  logic                 bit_now;
  logic                 was_s;
  logic [WORD_BITS-1:0] one_hot;
  logic [WORD_BITS-1:0] new_word;
  logic                 wr;

  for (genvar gi = 0; gi < 256; gi++) begin : g_tab
    assign qtab[gi] = 8'(gi / WORD_BITS);
    assign otab[gi] = OW'(gi % WORD_BITS);
  end

  assign ld_search = (req_data.action >= bfme_pkg::ACT_HIGH_SET) &&
                     (req_data.action <= bfme_pkg::ACT_LOW_ZERO);
  assign ld_high   = (req_data.action == bfme_pkg::ACT_HIGH_SET) ||
                     (req_data.action == bfme_pkg::ACT_HIGH_ZERO);
  assign ld_in_rng = (CW'(req_data.bit_index) < CW'(MAP_BITS));

  assign is_search = (act >= bfme_pkg::ACT_HIGH_SET) && (act <= bfme_pkg::ACT_LOW_ZERO);
  assign high      = (act == bfme_pkg::ACT_HIGH_SET) || (act == bfme_pkg::ACT_HIGH_ZERO);
  assign want      = (act == bfme_pkg::ACT_HIGH_SET) || (act == bfme_pkg::ACT_LOW_SET);
  assign iss_last  = !is_search || (high ? (iss_w == '0) : (iss_w == AW'(WORDS - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= bfme_pkg::BITS_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      bits_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_active <= 1'b0;
      ev_live    <= 1'b0;
    end else begin
      ev_live <= cmd.issue && iss_active && !cmd.commit;
      if (cmd.load) begin
        iss_active <= 1'b1;
      end else if (cmd.commit) begin
        iss_active <= 1'b0;
      end else if (cmd.issue && iss_active && iss_last) begin
        iss_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= req_data.action;
      in_rng <= ld_in_rng;
      off    <= otab[req_data.bit_index];
      limit  <= (CW'(bits_in_use) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(bits_in_use);
      if (ld_search && ld_high) begin
        iss_w    <= AW'(WORDS - 1);
        iss_base <= CW'((WORDS - 1) * WORD_BITS);
      end else if (ld_search) begin
        iss_w    <= '0;
        iss_base <= '0;
      end else begin
        iss_w    <= ld_in_rng ? qtab[req_data.bit_index][AW-1:0] : '0;
        iss_base <= '0;
      end
    end else if (cmd.issue && iss_active && !cmd.commit) begin
      ev_w    <= iss_w;
      ev_base <= iss_base;
      ev_last <= iss_last;
      if (!iss_last) begin
        if (high) begin
          iss_w    <= iss_w - AW'(1);
          iss_base <= iss_base - CW'(WORD_BITS);
        end else begin
          iss_w    <= iss_w + AW'(1);
          iss_base <= iss_base + CW'(WORD_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr) begin
      mem[ev_w] <= new_word;
    end
    if (cmd.issue) begin
      rdata  <= mem[iss_w];
      rvalid <= vbits[iss_w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (cmd.commit && wr) begin
      vbits[ev_w] <= 1'b1;
    end
  end

  assign data = rvalid ? rdata : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (({1'b0, ev_base} + (CW + 1)'(j)) < {1'b0, limit});
    end
    cand = (want ? data : ~data) & mask;
    hit  = |cand;
    pos  = '0;
    if (high) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (cand[j]) begin
          pos = OW'(j);
        end
      end
    end else begin
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
        if (cand[j]) begin
          pos = OW'(j);
        end
      end
    end
  end

  assign found_sum = {1'b0, ev_base} + (CW + 1)'(pos);
  assign bit_now   = data[off];
  assign was_s     = in_rng && bit_now;
  assign one_hot   = WORD_BITS'(1) << off;

  always_comb begin
    res      = '0;
    new_word = data;
    wr       = 1'b0;
    case (act)
      bfme_pkg::ACT_TEST: begin
        res.bit_was = was_s;
      end
      bfme_pkg::ACT_SET: begin
        res.bit_was = was_s;
        new_word    = data | one_hot;
        wr          = in_rng;
      end
      bfme_pkg::ACT_CLEAR: begin
        res.bit_was = was_s;
        new_word    = data & ~one_hot;
        wr          = in_rng;
      end
      bfme_pkg::ACT_FLIP: begin
        res.bit_was = was_s;
        new_word    = data ^ one_hot;
        wr          = in_rng;
      end
      bfme_pkg::ACT_TEST0_SET: begin
        res.bit_was = was_s;
        if (was_s) begin
          res.status = bfme_pkg::STATUS_REFUSED;
        end else begin
          new_word = data | one_hot;
          wr       = in_rng;
        end
      end
      bfme_pkg::ACT_TEST1_CLR: begin
        res.bit_was = was_s;
        if (!was_s) begin
          res.status = bfme_pkg::STATUS_REFUSED;
        end else begin
          new_word = data & ~one_hot;
          wr       = in_rng;
        end
      end
      bfme_pkg::ACT_HIGH_SET, bfme_pkg::ACT_HIGH_ZERO,
      bfme_pkg::ACT_LOW_SET, bfme_pkg::ACT_LOW_ZERO: begin
        if (hit) begin
          res.status         = bfme_pkg::STATUS_OK;
          res.bit_was        = want;
          res.found_position = found_sum[7:0];
          new_word           = data ^ (WORD_BITS'(1) << pos);
          wr                 = 1'b1;
        end else begin
          res.status = bfme_pkg::STATUS_NONE;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign sts.eval_done = ev_live && (ev_last || (is_search && hit));

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend <= res;
    end
    if (cmd.out_direct) begin
      rsp_data <= res;
    end else if (cmd.out_pend) begin
      rsp_data <= pend;
    end
  end

endmodule

// ----- src/bitmap_find_and_modify_engine_unit.sv -----
// Channel   Direction  Signals                        Word
// request   in         req_valid, req_ready, req_data  action, bit_index
// response  out        rsp_valid, rsp_ready, rsp_data  status, bit_was, found_position
// config    in         cfg_wr_en, cfg_wr_data          bits_in_use
//
// A single-bit action reads its word, then evaluates and commits it, and registers its result.
// A search scans the map in words and ends at the first word with a hit or at the last word,
// paced by the one-word-per-cycle read port of the bitmap memory and its encoder.
// The next word can be accepted in the same cycle that a result is offered.
// Reset clears the map at once through per-word valid bits and sets bits_in_use to 256.
// A stalled response is held in the output register while the next word is accepted.
module bitmap_find_and_modify_engine_unit #(
  parameter int WORD_BITS = 32,
  parameter int WORDS     = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bfme_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bfme_pkg::rsp_t rsp_data,
  input  logic           cfg_wr_en,
  input  logic [8:0]     cfg_wr_data
);

  bfme_pkg::cmd_t cmd;
  bfme_pkg::sts_t sts;

  bfme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfme_datapath #(
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_data    (req_data),
    .rsp_data    (rsp_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while an earlier word is still in progress");

  a_no_load_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.commit))
    else $error("load and commit issued together");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.out_direct || cmd.out_pend))
    else $error("response raised without a result being loaded");

endmodule
